FILE: rtl/assert_macros.svh
// Assertion helpers used by the checker file.
// Each macro expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/sff_pkg.sv
package sff_pkg;

  localparam int unsigned TapsDefault = 81;
  localparam int unsigned SampleW     = 16;
  localparam int unsigned CoefW       = 16;
  localparam int unsigned BankW       = 2;
  localparam int unsigned CoefIdxW    = 7;
  localparam int unsigned SwitchW     = 4;
  localparam int unsigned ProdW       = 32;
  localparam int unsigned AccW        = 40;
  localparam int unsigned InDataW     = 64;
  localparam int unsigned OutDataW    = 32;

  // Switch bit positions
  localparam int unsigned SwBypass = 0;
  localparam int unsigned SwLow    = 1;
  localparam int unsigned SwBand   = 2;
  localparam int unsigned SwHigh   = 3;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [CoefW-1:0]   coef_t;
  typedef logic signed [ProdW-1:0]   prod_t;
  typedef logic signed [AccW-1:0]    acc_t;

  localparam acc_t AccMax   = {1'b0, {(AccW-1){1'b1}}};
  localparam acc_t AccMin   = {1'b1, {(AccW-1){1'b0}}};
  localparam acc_t RoundPos = 40'sd16384;
  localparam acc_t RoundNeg = -40'sd16384;

  typedef enum logic [BankW-1:0] {
    BANK_LOW  = 2'd0,
    BANK_BAND = 2'd1,
    BANK_HIGH = 2'd2
  } bank_e;

  // Control for one history cell
  typedef struct packed {
    logic push;
    logic rot;
  } cell_ctrl_t;

  // Control for one multiply-accumulate lane
  typedef struct packed {
    logic clear;
    logic valid;
    logic round;
  } mac_ctrl_t;

  // Doubled Q15 product, saturated to 32 bits
  function automatic prod_t dmul(sample_t a, coef_t b);
    prod_t p;
    p = a * b;
    if (p == 32'sh4000_0000) begin
      return 32'sh7FFF_FFFF;
    end
    return {p[ProdW-2:0], 1'b0};
  endfunction

  // Saturating 40-bit add
  function automatic acc_t sat_add(acc_t a, acc_t b);
    logic [AccW:0] s;
    s = {a[AccW-1], a} + {b[AccW-1], b};
    if (s[AccW] != s[AccW-1]) begin
      return s[AccW] ? AccMin : AccMax;
    end
    return s[AccW-1:0];
  endfunction

  // Shift right 15 (floor) and saturate to 16 bits
  function automatic sample_t sat_out(acc_t a);
    logic signed [AccW-16:0] sh;
    sh = a[AccW-1:15];
    if (sh > 25'sd32767) begin
      return 16'sh7FFF;
    end
    if (sh < -25'sd32768) begin
      return 16'sh8000;
    end
    return sh[SampleW-1:0];
  endfunction

endpackage

FILE: rtl/sff_cell.sv
module sff_cell
  import sff_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  sample_t    push_l_i,
  input  sample_t    push_r_i,
  input  sample_t    rot_l_i,
  input  sample_t    rot_r_i,
  output sample_t    l_o,
  output sample_t    r_o
);

  sample_t l_q, r_q;

  // Take the newer neighbor's pair on push, the next tap's pair on rotate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l_q <= '0;
      r_q <= '0;
    end else if (ctrl_i.push) begin
      l_q <= push_l_i;
      r_q <= push_r_i;
    end else if (ctrl_i.rot) begin
      l_q <= rot_l_i;
      r_q <= rot_r_i;
    end
  end

  assign l_o = l_q;
  assign r_o = r_q;

endmodule

FILE: rtl/sff_mac.sv
module sff_mac
  import sff_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  mac_ctrl_t ctrl_i,
  input  sample_t   sample_i,
  input  coef_t     coef_i,
  output sample_t   result_o,
  output logic      busy_o
);

  prod_t prod_q;
  logic  prod_vld_q;
  acc_t  acc_q;

  // Register the doubled product
  always_ff @(posedge clk_i) begin
    if (ctrl_i.valid) begin
      prod_q <= dmul(sample_i, coef_i);
    end
  end

  // Accumulate, then round away from zero by 2^14
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      acc_q      <= '0;
    end else begin
      prod_vld_q <= ctrl_i.valid;
      if (ctrl_i.clear) begin
        acc_q <= '0;
      end else if (prod_vld_q) begin
        acc_q <= sat_add(acc_q, {{(AccW-ProdW){prod_q[ProdW-1]}}, prod_q});
      end else if (ctrl_i.round) begin
        acc_q <= sat_add(acc_q, acc_q[AccW-1] ? RoundNeg : RoundPos);
      end
    end
  end

  assign result_o = sat_out(acc_q);
  assign busy_o   = prod_vld_q;

endmodule

FILE: rtl/stereo_selectable_fir_filter.sv
// Stereo FIR filter with bypass and three loaded coefficient banks.
// Input channel s_axis_*: tuser[0] = 0 carries a left/right sample pair,
// tuser[0] = 1 writes one coefficient (bank, tap index, value). A write
// to bank 3 or to a tap index at or above TAPS is dropped.
// Output channel m_axis_*: one left/right pair per sample item, none per
// coefficient write. cfg_we_i/cfg_wdata_i load the switch register
// (bit0 bypass, bit1 lowpass, bit2 bandpass, bit3 highpass, lowest set
// bit wins); write it only while no item is in flight.
// A coefficient write leaves the input ready; a bypass or all-off
// sample goes straight to the output load step. A filtered sample
// rotates the history cells past one multiply-accumulate per channel,
// one tap and one coefficient read per cycle, then drains the
// pipeline, takes a rounding step and loads the output register.
// s_axis_tready stays low from a sample's acceptance until its result
// sits in the output register; a new item is taken while that result
// still waits. If the receiver stalls, the next result waits in its
// load step until the output register frees up.
// Reset clears the history cells to zero, the switches to zero and the
// control; the coefficient memory holds garbage until written.
module stereo_selectable_fir_filter
  import sff_pkg::*;
#(
  parameter int unsigned TAPS = TapsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [SwitchW-1:0]  cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [15:0] sample_left, [31:16] sample_right, [33:32] coef_bank,
  // [40:34] coef_index, [56:41] coef_value, [63:57] zero
  input  logic [InDataW-1:0]  s_axis_tdata,
  // [0] mode
  input  logic [0:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [15:0] out_left, [31:16] out_right
  output logic [OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned CntW     = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int unsigned MemDepth = 3 * TAPS;
  localparam int unsigned AddrW    = $clog2(MemDepth);
  localparam logic [AddrW-1:0] BaseBand = AddrW'(TAPS);
  localparam logic [AddrW-1:0] BaseHigh = AddrW'(2 * TAPS);
  localparam logic [CntW-1:0]  LastTap  = CntW'(TAPS - 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_RUN   = 5'b00010,
    S_DRAIN = 5'b00100,
    S_ROUND = 5'b01000,
    S_LOAD  = 5'b10000
  } state_e;

  typedef enum logic [1:0] {
    SEL_ZERO   = 2'd0,
    SEL_BYPASS = 2'd1,
    SEL_FIR    = 2'd2
  } sel_e;

  state_e state_q;
  sel_e   sel_q, sel_d;
  logic [SwitchW-1:0] switches_q;
  logic [CntW-1:0]    cnt_q;
  logic [AddrW-1:0]   base_q, base_d;
  logic               tap_vld_q;
  sample_t            tap_l_q, tap_r_q;
  coef_t              coef_rd_q;
  logic               out_vld_q;
  logic [OutDataW-1:0] out_data_q;

  // Unpack the input fields
  sample_t             in_left, in_right;
  logic [BankW-1:0]    in_bank;
  logic [CoefIdxW-1:0] in_idx;
  coef_t               in_value;

  assign in_left  = s_axis_tdata[15:0];
  assign in_right = s_axis_tdata[31:16];
  assign in_bank  = s_axis_tdata[33:32];
  assign in_idx   = s_axis_tdata[40:34];
  assign in_value = s_axis_tdata[56:41];

  logic in_acc, smp_acc, coef_acc, out_free;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign smp_acc  = in_acc && !s_axis_tuser[0];
  assign coef_acc = in_acc && s_axis_tuser[0];
  assign out_free = !out_vld_q || m_axis_tready;

  // Hold the switch register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      switches_q <= '0;
    end else if (cfg_we_i) begin
      switches_q <= cfg_wdata_i;
    end
  end

  // Pick the output path and the bank base from the switches
  always_comb begin
    if (switches_q[SwBypass]) begin
      sel_d = SEL_BYPASS;
    end else if (switches_q[SwLow] || switches_q[SwBand] || switches_q[SwHigh]) begin
      sel_d = SEL_FIR;
    end else begin
      sel_d = SEL_ZERO;
    end
    if (switches_q[SwLow]) begin
      base_d = '0;
    end else if (switches_q[SwBand]) begin
      base_d = BaseBand;
    end else begin
      base_d = BaseHigh;
    end
  end

  // Coefficient write address and range check
  logic [AddrW-1:0] wr_base, wr_addr, rd_addr;
  logic             wr_en;

  always_comb begin
    case (in_bank)
      BANK_LOW:  wr_base = '0;
      BANK_BAND: wr_base = BaseBand;
      default:   wr_base = BaseHigh;
    endcase
  end

  assign wr_en   = coef_acc && (in_bank <= BANK_HIGH) && (32'(in_idx) < 32'(TAPS));
  assign wr_addr = wr_base + AddrW'(in_idx);
  assign rd_addr = base_q + AddrW'(cnt_q);

  // Coefficient memory: one write port, one registered read port
  coef_t coef_mem [MemDepth];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      coef_mem[wr_addr] <= in_value;
    end
    coef_rd_q <= coef_mem[rd_addr];
  end

  // History cells: cell 0 holds the newest pair, the last one the oldest tap
  cell_ctrl_t cell_ctrl;
  sample_t    cell_l [TAPS];
  sample_t    cell_r [TAPS];
  sample_t    push_l [TAPS];
  sample_t    push_r [TAPS];
  sample_t    rot_l  [TAPS];
  sample_t    rot_r  [TAPS];

  assign cell_ctrl.push = smp_acc;
  assign cell_ctrl.rot  = (state_q == S_RUN);

  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign push_l[k] = in_left;
      assign push_r[k] = in_right;
    end else begin : g_body
      assign push_l[k] = cell_l[k-1];
      assign push_r[k] = cell_r[k-1];
    end
    if (k == TAPS - 1) begin : g_wrap
      assign rot_l[k] = cell_l[0];
      assign rot_r[k] = cell_r[0];
    end else begin : g_next
      assign rot_l[k] = cell_l[k+1];
      assign rot_r[k] = cell_r[k+1];
    end

    sff_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (cell_ctrl),
      .push_l_i (push_l[k]),
      .push_r_i (push_r[k]),
      .rot_l_i  (rot_l[k]),
      .rot_r_i  (rot_r[k]),
      .l_o      (cell_l[k]),
      .r_o      (cell_r[k])
    );
  end

  // Capture the head tap alongside the memory read
  always_ff @(posedge clk_i) begin
    if (state_q == S_RUN) begin
      tap_l_q <= cell_l[0];
      tap_r_q <= cell_r[0];
    end
  end

  // One multiply-accumulate lane per channel
  mac_ctrl_t mac_ctrl;
  sample_t   res_l, res_r;
  logic      mac_busy, mac_busy_r;

  assign mac_ctrl.clear = smp_acc;
  assign mac_ctrl.valid = tap_vld_q;
  assign mac_ctrl.round = (state_q == S_ROUND);

  sff_mac u_mac_l (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .sample_i (tap_l_q),
    .coef_i   (coef_rd_q),
    .result_o (res_l),
    .busy_o   (mac_busy)
  );

  sff_mac u_mac_r (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .sample_i (tap_r_q),
    .coef_i   (coef_rd_q),
    .result_o (res_r),
    .busy_o   (mac_busy_r)
  );

  // Sequence one sample item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      sel_q     <= SEL_ZERO;
      cnt_q     <= '0;
      base_q    <= '0;
      tap_vld_q <= 1'b0;
    end else begin
      tap_vld_q <= (state_q == S_RUN);
      case (state_q)
        S_IDLE: begin
          if (smp_acc) begin
            sel_q  <= sel_d;
            base_q <= base_d;
            cnt_q  <= '0;
            state_q <= (sel_d == SEL_FIR) ? S_RUN : S_LOAD;
          end
        end
        S_RUN: begin
          cnt_q <= cnt_q + CntW'(1);
          if (cnt_q == LastTap) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!tap_vld_q && !mac_busy && !mac_busy_r) begin
            state_q <= S_ROUND;
          end
        end
        S_ROUND: begin
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: load in the load step, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (state_q == S_LOAD && out_free) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_LOAD && out_free) begin
      case (sel_q)
        SEL_BYPASS: out_data_q <= {cell_r[0], cell_l[0]};
        SEL_FIR:    out_data_q <= {res_r, res_l};
        default:    out_data_q <= '0;
      endcase
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

FILE: rtl/sff_checker.sv
`include "assert_macros.svh"

module sff_checker
  import sff_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [0:0]          s_axis_tuser,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  // A stalled result holds
  `ASSERT_NEXT(a_hold_result, m_axis_tvalid && !m_axis_tready,
               m_axis_tvalid && $stable(m_axis_tdata))

  // A sample item closes the input in the cycle after its acceptance
  `ASSERT_NEXT(a_busy_after_sample, s_axis_tvalid && s_axis_tready && !s_axis_tuser[0],
               !s_axis_tready)

  // A coefficient write leaves the input open
  `ASSERT_NEXT(a_open_after_coef, s_axis_tvalid && s_axis_tready && s_axis_tuser[0],
               s_axis_tready)

  // A new result only appears out of a busy cycle
  `ASSERT_NOW(a_result_from_busy, m_axis_tvalid && !$past(m_axis_tvalid),
              !$past(s_axis_tready))

endmodule

bind stereo_selectable_fir_filter sff_checker u_sff_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: test/stereo_selectable_fir_filter_tb.sv
`timescale 1ns / 1ps

module stereo_selectable_fir_filter_tb;
  import sff_pkg::*;

  localparam int unsigned TAPS = TapsDefault;
  localparam int unsigned HIST_DEPTH = TAPS - 1;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned PHASE_ITEMS = 22;
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_COEF = 1'b1;
  localparam logic [BankW-1:0] BANK_NONE = 2'd3;
  localparam longint ACC_HI = 64'sd549755813887;
  localparam longint ACC_LO = -64'sd549755813888;
  localparam longint ROUND_STEP = 64'sd16384;

  typedef struct packed {
    sample_t right;
    sample_t left;
  } stereo_pair_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [SwitchW-1:0]  cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  // [15:0] sample_left, [31:16] sample_right, [33:32] coef_bank,
  // [40:34] coef_index, [56:41] coef_value, [63:57] zero
  logic [InDataW-1:0]  s_axis_tdata;
  // [0] mode
  logic [0:0]          s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // [15:0] out_left, [31:16] out_right
  logic [OutDataW-1:0] m_axis_tdata;

  // Filter state as the block should hold it
  sample_t            hist_q[2][HIST_DEPTH];
  coef_t              coef_mem[3][TAPS];
  logic [SwitchW-1:0] switches;
  stereo_pair_t       expected_pairs[$];

  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned quiet_cycles;
  int unsigned rx_seen;
  int unsigned rx_hold;
  bit          tx_gaps_on;
  bit          rx_stalls_on;

  stereo_selectable_fir_filter u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic longint clamp_acc(longint v);
    if (v > ACC_HI) begin
      return ACC_HI;
    end
    if (v < ACC_LO) begin
      return ACC_LO;
    end
    return v;
  endfunction

  // Q15 x Q15 doubled; only -1 x -1 overflows
  function automatic longint doubled_product(sample_t a, coef_t b);
    longint p;
    p = longint'(a) * longint'(b) * 2;
    if (p > 64'sd2147483647) begin
      p = 64'sd2147483647;
    end
    return p;
  endfunction

  function automatic sample_t filter_tap_sum(int ch, sample_t cur, bank_e bank);
    longint acc;
    longint shifted;
    acc = clamp_acc(doubled_product(cur, coef_mem[int'(bank)][0]));
    for (int j = 1; j < TAPS; j++) begin
      acc = clamp_acc(acc + doubled_product(hist_q[ch][j-1], coef_mem[int'(bank)][j]));
    end
    // Round half away from zero, then floor shift
    acc = clamp_acc(acc + ((acc >= 0) ? ROUND_STEP : -ROUND_STEP));
    shifted = acc >>> 15;
    if (shifted > 32767) begin
      shifted = 32767;
    end
    if (shifted < -32768) begin
      shifted = -32768;
    end
    return sample_t'(shifted[15:0]);
  endfunction

  // Apply one accepted item to the filter state; queue its output pair
  function automatic void predict_item(logic mode, logic [InDataW-1:0] data);
    logic [BankW-1:0]    wbank;
    logic [CoefIdxW-1:0] widx;
    sample_t             l;
    sample_t             r;
    stereo_pair_t        pair;
    bank_e               bank;
    wbank = data[33:32];
    widx  = data[40:34];
    l     = data[15:0];
    r     = data[31:16];
    if (mode == MODE_COEF) begin
      // Drop writes to the unused bank or past the last tap
      if (wbank != BANK_NONE && int'(widx) < TAPS) begin
        coef_mem[int'(wbank)][int'(widx)] = data[56:41];
      end
      return;
    end
    if (switches[SwBypass]) begin
      pair.left  = l;
      pair.right = r;
    end else if (switches[SwLow] || switches[SwBand] || switches[SwHigh]) begin
      bank = switches[SwLow] ? BANK_LOW : (switches[SwBand] ? BANK_BAND : BANK_HIGH);
      pair.left  = filter_tap_sum(0, l, bank);
      pair.right = filter_tap_sum(1, r, bank);
    end else begin
      pair = '0;
    end
    expected_pairs.push_back(pair);
    // History takes the new pair whatever the switches say
    for (int j = HIST_DEPTH - 1; j > 0; j--) begin
      hist_q[0][j] = hist_q[0][j-1];
      hist_q[1][j] = hist_q[1][j-1];
    end
    hist_q[0][0] = l;
    hist_q[1][0] = r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic sample_t rand_sample();
    logic [15:0] raw;
    case ($urandom_range(0, 5))
      0:       raw = 16'h7FFF;
      1:       raw = 16'h8000;
      2, 3:    raw = 16'($urandom);
      default: raw = 16'($urandom_range(0, 4095)) - 16'd2048;
    endcase
    return sample_t'(raw);
  endfunction

  // Mostly small taps so that filtered outputs stay off the rails
  function automatic coef_t rand_coef();
    logic [15:0] raw;
    case ($urandom_range(0, 9))
      0:       raw = 16'h7FFF;
      1:       raw = 16'h8000;
      2, 3:    raw = 16'($urandom);
      default: raw = 16'($urandom_range(0, 2047)) - 16'd1024;
    endcase
    return coef_t'(raw);
  endfunction

  function automatic logic [InDataW-1:0] pack_item(sample_t l, sample_t r,
                                                  logic [BankW-1:0] bank,
                                                  logic [CoefIdxW-1:0] idx, coef_t val);
    return {7'b0, val, idx, bank, r, l};
  endfunction

  task automatic send_item(input logic mode, input logic [InDataW-1:0] data);
    int unsigned gap;
    gap = tx_gaps_on ? $urandom_range(0, 15) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_item(mode, data);
  endtask

  task automatic send_sample(input sample_t l, input sample_t r);
    send_item(MODE_SAMPLE, pack_item(l, r, 2'($urandom), 7'($urandom), rand_coef()));
  endtask

  task automatic send_coef(input logic [BankW-1:0] bank, input logic [CoefIdxW-1:0] idx,
                           input coef_t val);
    send_item(MODE_COEF, pack_item(rand_sample(), rand_sample(), bank, idx, val));
  endtask

  // Hold the sender until every queued pair is back, then let the block settle
  task automatic wait_for_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_pairs.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_switches(input logic [SwitchW-1:0] value);
    wait_for_results();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    switches = value;
  endtask

  // Fill a whole bank; saturating fills every tap with -1.0
  task automatic load_bank(input bank_e bank, input bit saturating, inout int unsigned count);
    for (int i = 0; i < TAPS; i++) begin
      send_coef(bank, CoefIdxW'(i), saturating ? coef_t'(16'h8000) : rand_coef());
      count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Switches come out of reset all off: every pair reads as zero
  task automatic test_switches_off();
    send_sample(16'sh7FFF, 16'sh8000);
    send_sample(16'sh8000, 16'sh7FFF);
    send_sample(16'sh0000, 16'shFFFF);
    send_sample(rand_sample(), rand_sample());
  endtask

  // Bypass copies the pair, and it wins over every filter bit
  task automatic test_bypass();
    set_switches(4'b0001);
    send_sample(16'sh7FFF, 16'sh8000);
    send_sample(16'sh8000, 16'sh0001);
    send_sample(16'shFFFF, 16'sh0000);
    set_switches(4'b1111);
    send_sample(16'sh1234, 16'shEDCB);
    send_sample(16'sh8000, 16'sh7FFF);
  endtask

  // Load all three banks; writes to bad addresses must leave them alone
  task automatic test_coef_load();
    int unsigned dummy;
    dummy = 0;
    load_bank(BANK_LOW, 1'b1, dummy);
    load_bank(BANK_BAND, 1'b0, dummy);
    load_bank(BANK_HIGH, 1'b0, dummy);
    send_coef(BANK_NONE, 7'd0, 16'sh7FFF);
    send_coef(BANK_NONE, 7'd127, 16'sh8000);
    send_coef(BANK_LOW, 7'd81, 16'sh7FFF);
    send_coef(BANK_HIGH, 7'd127, 16'sh7FFF);
  endtask

  // Low bank holds -1.0 everywhere: drive both output rails; then try the high and band banks
  task automatic test_filter_extremes();
    set_switches(4'b0010);
    send_sample(16'sh8000, 16'sh7FFF);
    send_sample(16'sh8000, 16'sh7FFF);
    send_sample(16'sh7FFF, 16'sh8000);
    send_sample(16'sh0000, 16'sh0001);
    set_switches(4'b0110);
    send_sample(rand_sample(), rand_sample());
    send_sample(16'sh7FFF, 16'sh8000);
    set_switches(4'b1000);
    send_sample(rand_sample(), rand_sample());
    send_sample(16'sh8000, 16'sh8000);
    set_switches(4'b1100);
    send_sample(rand_sample(), rand_sample());
  endtask

  // Random phases over all switch settings with mixed coefficient updates
  task automatic test_random_traffic();
    int unsigned counted;
    int unsigned loaded;
    int unsigned pick;
    loaded = 0;
    for (int phase = 0; phase < 16; phase++) begin
      set_switches(SwitchW'(phase));
      tx_gaps_on   = ($urandom_range(0, 2) != 0);
      rx_stalls_on = ($urandom_range(0, 2) != 0);
      counted = 0;
      // Refresh a bank now and then with a full, well-formed load
      if ($urandom_range(0, 3) == 0) begin
        load_bank(bank_e'($urandom_range(0, 2)), 1'b0, loaded);
      end
      while (counted < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          send_coef(2'($urandom_range(0, 2)), 7'($urandom_range(0, TAPS - 1)), rand_coef());
          counted++;
        end else if (pick < 14) begin
          if ($urandom_range(0, 1) == 0) begin
            send_coef(BANK_NONE, 7'($urandom), rand_coef());
          end else begin
            send_coef(2'($urandom_range(0, 2)), 7'($urandom_range(TAPS, 127)), rand_coef());
          end
        end else begin
          send_sample(rand_sample(), rand_sample());
          counted++;
        end
        if ($urandom_range(0, 29) == 0) begin
          wait_for_results();
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic note_failure(input string what, input sample_t want, input sample_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("mismatch on result %0d, %s: expected %0d, got %0d",
               results_seen, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin : check_results
    stereo_pair_t got;
    stereo_pair_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      results_seen++;
      if (expected_pairs.size() == 0) begin
        note_failure("no pair expected, left", 16'sd0, got.left);
      end else begin
        want = expected_pairs.pop_front();
        if (got.left !== want.left) begin
          note_failure("left", want.left, got.left);
        end
        if (got.right !== want.right) begin
          note_failure("right", want.right, got.right);
        end
      end
    end
  end

  // Receiver stalls: draw a fresh hold after every accepted item
  always @(negedge clk_i) begin
    if (results_seen != rx_seen) begin
      rx_seen = results_seen;
      rx_hold = rx_stalls_on ? $urandom_range(0, 15) : 0;
    end
    if (rx_hold > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog on cycles without any accepted item
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = MODE_SAMPLE;
    m_axis_tready = 1'b0;
    switches      = '0;
    mismatches    = 0;
    results_seen  = 0;
    quiet_cycles  = 0;
    rx_seen       = 0;
    rx_hold       = 0;
    tx_gaps_on    = 1'b1;
    rx_stalls_on  = 1'b1;
    for (int ch = 0; ch < 2; ch++) begin
      for (int j = 0; j < HIST_DEPTH; j++) begin
        hist_q[ch][j] = '0;
      end
    end
    for (int b = 0; b < 3; b++) begin
      for (int j = 0; j < TAPS; j++) begin
        coef_mem[b][j] = '0;
      end
    end
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    test_switches_off();
    test_bypass();
    test_coef_load();
    test_filter_extremes();
    test_random_traffic();

    wait_for_results();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/sff_pkg.sv
rtl/sff_cell.sv
rtl/sff_mac.sv
rtl/stereo_selectable_fir_filter.sv
rtl/sff_checker.sv
test/stereo_selectable_fir_filter_tb.sv
